// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked while reset is high
`define TLD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tld assertion failed");

// property checked on every rising edge, reset included
`define TLD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("tld assertion failed");

`endif

// File: hw/rtl/tld_pkg.sv
// ----------------------------------------------------------------------------
// tld_pkg
// types, constants and register codes of the tty line discipline
// ----------------------------------------------------------------------------
package tld_pkg;

   // line buffer geometry
   localparam int LINE_DEPTH = 32;
   localparam int IDX_W      = $clog2(LINE_DEPTH);
   localparam int LEN_W      = $clog2(LINE_DEPTH + 1);

   // configuration port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 64;
   localparam int REG_W  = 2;

   typedef enum logic [REG_W-1:0] {
      REG_MODE    = 2'd0,
      REG_ERASE   = 2'd1,
      REG_INTR    = 2'd2,
      REG_IGNORED = 2'd3
   } tld_reg_type;

   localparam logic [6:0]  MODE_RESET    = 7'd63;
   localparam logic [7:0]  ERASE_RESET   = 8'h00;
   localparam logic [7:0]  INTR_RESET    = 8'h03;
   localparam logic [47:0] IGNORED_RESET = 48'h1A111C150000;

   // mode flag bit positions
   localparam int M_CANON  = 0;
   localparam int M_ECHO   = 1;
   localparam int M_ECHOE  = 2;
   localparam int M_ICRNL  = 3;
   localparam int M_OPOST  = 4;
   localparam int M_ONLCR  = 5;
   localparam int M_OCRNL  = 6;

   // character codes
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CARET_OFS = 8'h40;
   localparam logic [7:0] CTRL_TOP  = 8'h20;

   // item sources and result streams
   localparam logic ACT_KEYBOARD = 1'b0;
   localparam logic ACT_PROGRAM  = 1'b1;
   localparam logic DST_DISPLAY  = 1'b0;
   localparam logic DST_READER   = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } tld_req_type;

   typedef struct packed {
      logic       destination;
      logic [7:0] out_byte;
      logic       interrupt_request;
      logic       last;
   } tld_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DISP,
      ST_FLUSH
   } tld_state_type;

endpackage

// File: hw/rtl/tty_line_discipline.sv
// ----------------------------------------------------------------------------
// tty_line_discipline
// canonical terminal line discipline: echo, erase, interrupt, line flush
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | beat
//  ---------+-----------+------------------------+---------------------------
//  req      | in        | req_valid / req_ready  | action, data_byte
//  rsp      | out       | rsp_valid / rsp_ready  | destination, out_byte, irq, last
//  csr      | in        | apb psel/penable/pready| 64 bit registers at 8*index
//
//  an item is taken in the idle state and then gives one result beat per cycle
//  through the output register unless rsp_ready stalls it: a short display
//  sequence of up to four beats, then for a line end the buffered line read from
//  the line memory, one byte a cycle unless stalled; the line memory read port
//  is pipelined one entry ahead, so a stalled rsp side just holds the read
//  address; reset clears the fsm, the line length and the registers, the line
//  memory itself needs no clearing
//
module tty_line_discipline (
   input  logic                       clock,
   input  logic                       reset,
   // input channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tld_pkg::tld_req_type       req_payload,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output tld_pkg::tld_rsp_type       rsp_payload,
   // configuration port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [tld_pkg::CSR_AW-1:0] paddr,
   input  logic [tld_pkg::CSR_DW-1:0] pwdata,
   output logic [tld_pkg::CSR_DW-1:0] prdata,
   output logic                       pready
);
   import tld_pkg::*;

   // configuration registers
   logic [6:0]  mode_ff;
   logic [7:0]  erase_ff;
   logic [7:0]  intr_ff;
   logic [47:0] ignored_ff;

   // sequencer state
   tld_state_type       state_ff, state_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [2:0][7:0]     slot_ff, slot_in;     // display bytes still to send
   logic [1:0]          cnt_ff, cnt_in;       // number of valid slots
   logic [1:0]          idx_ff, idx_in;       // slot being sent
   logic                half_ff, half_in;     // cr of a cr lf pair already sent
   logic                dest_ff, dest_in;     // stream of the slot bytes
   logic                flush_ff, flush_in;   // line flush follows the slots
   logic                irq_ff, irq_in;
   logic                first_ff, first_in;   // next beat is the item's first
   logic [IDX_W-1:0]    fidx_ff, fidx_in;     // flush read position
   logic [IDX_W-1:0]    fend_ff, fend_in;     // index of the stored lf

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   tld_rsp_type         rsp_ff, rsp_in;

   // line memory
   logic [7:0]          line_mem [LINE_DEPTH];
   logic [7:0]          rdata_ff;
   logic                wr_en;
   logic [7:0]          wr_data;

   logic                cfg_wr;
   tld_reg_type         cfg_sel;
   logic                req_take;
   logic                out_free;

   // ---------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------
   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign cfg_sel = tld_reg_type'(paddr[CSR_AW-1:CSR_AW-REG_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_RESET;
         erase_ff   <= ERASE_RESET;
         intr_ff    <= INTR_RESET;
         ignored_ff <= IGNORED_RESET;
      end else if (cfg_wr) begin
         unique case (cfg_sel)
            REG_MODE:    mode_ff    <= pwdata[6:0];
            REG_ERASE:   erase_ff   <= pwdata[7:0];
            REG_INTR:    intr_ff    <= pwdata[7:0];
            REG_IGNORED: ignored_ff <= pwdata[47:0];
         endcase
      end
   end

   always_comb begin
      unique case (cfg_sel)
         REG_MODE:    prdata = {{(CSR_DW-7){1'b0}}, mode_ff};
         REG_ERASE:   prdata = {{(CSR_DW-8){1'b0}}, erase_ff};
         REG_INTR:    prdata = {{(CSR_DW-8){1'b0}}, intr_ff};
         REG_IGNORED: prdata = {{(CSR_DW-48){1'b0}}, ignored_ff};
      endcase
   end

   // ---------------------------------------------------------------------
   // handshake
   // ---------------------------------------------------------------------
   assign req_ready   = (state_ff == ST_IDLE);
   assign req_take    = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------------------------------------------------------------
   // decode, display sequencing and line flush
   // ---------------------------------------------------------------------
   always_comb begin
      logic [7:0] c;
      logic       ign_eof_eol;
      logic       ign_any;
      logic       is_erase;
      logic       is_intr;
      logic       is_eol;
      logic       echo;
      logic [7:0] b;
      logic       post;
      logic       need_crlf;
      logic       map_cr;
      logic       step_done;
      logic       final_slot;

      c           = req_payload.data_byte;
      ign_eof_eol = (c == ignored_ff[7:0]) || (c == ignored_ff[15:8]);
      ign_any     = ign_eof_eol || (c == ignored_ff[23:16]) || (c == ignored_ff[31:24])
                    || (c == ignored_ff[39:32]) || (c == ignored_ff[47:40]);
      is_erase    = (c == erase_ff) || (c == CH_BS);
      is_intr     = (c == intr_ff);
      is_eol      = (c == CH_LF) || ((c == CH_CR) && mode_ff[M_ICRNL]);
      echo        = mode_ff[M_ECHO];

      b          = slot_ff[idx_ff];
      post       = (dest_ff == DST_DISPLAY) && mode_ff[M_OPOST];
      need_crlf  = post && mode_ff[M_ONLCR] && (b == CH_LF);
      map_cr     = post && mode_ff[M_OCRNL] && (b == CH_CR);
      step_done  = !need_crlf || half_ff;
      final_slot = ((idx_ff + 2'd1) == cnt_ff);

      state_in     = state_ff;
      len_in       = len_ff;
      slot_in      = slot_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      half_in      = half_ff;
      dest_in      = dest_ff;
      flush_in     = flush_ff;
      irq_in       = irq_ff;
      first_in     = first_ff;
      fidx_in      = fidx_ff;
      fend_in      = fend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_data      = c;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               slot_in  = '0;
               cnt_in   = 2'd0;
               idx_in   = 2'd0;
               half_in  = 1'b0;
               dest_in  = DST_DISPLAY;
               flush_in = 1'b0;
               irq_in   = 1'b0;
               first_in = 1'b1;
               fidx_in  = '0;
               if (req_payload.action == ACT_PROGRAM) begin
                  slot_in[0] = c;
                  cnt_in     = 2'd1;
               end else if (!mode_ff[M_CANON]) begin
                  // raw mode: straight to the reader
                  slot_in[0] = c;
                  cnt_in     = 2'd1;
                  dest_in    = DST_READER;
               end else begin
                  priority if (ign_eof_eol) begin
                     cnt_in = 2'd0;
                  end else if (is_erase) begin
                     if (len_ff != '0) begin
                        len_in = len_ff - LEN_W'(1);
                        if (mode_ff[M_ECHOE]) begin
                           slot_in = {CH_BS, CH_SPACE, CH_BS};
                           cnt_in  = 2'd3;
                        end
                     end
                  end else if (is_intr) begin
                     slot_in = {CH_LF, c + CARET_OFS, CH_CARET};
                     cnt_in  = 2'd3;
                     irq_in  = 1'b1;
                  end else if (ign_any) begin
                     cnt_in = 2'd0;
                  end else if (is_eol) begin
                     // store lf and send the whole line
                     wr_en    = 1'b1;
                     wr_data  = CH_LF;
                     fend_in  = len_ff[IDX_W-1:0];
                     len_in   = '0;
                     flush_in = 1'b1;
                     if (echo) begin
                        slot_in[0] = CH_LF;
                        cnt_in     = 2'd1;
                     end
                  end else if (len_ff < LEN_W'(LINE_DEPTH - 1)) begin
                     wr_en  = 1'b1;
                     len_in = len_ff + LEN_W'(1);
                  end else begin
                     // full line: dropped, no echo
                     cnt_in = 2'd0;
                  end

                  // ordinary and ignored characters echo, control bytes in caret form
                  if (echo && (ign_eof_eol || (!is_erase && !is_intr && (ign_any
                      || (!is_eol && len_ff < LEN_W'(LINE_DEPTH - 1)))))) begin
                     if (c < CTRL_TOP) begin
                        slot_in[0] = CH_CARET;
                        slot_in[1] = c + CARET_OFS;
                        cnt_in     = 2'd2;
                     end else begin
                        slot_in[0] = c;
                        cnt_in     = 2'd1;
                     end
                  end
               end
               if ((cnt_in != 2'd0) || flush_in) begin
                  state_in = ST_DISP;
               end
            end
         end

         ST_DISP: begin
            if (cnt_ff == 2'd0) begin
               state_in = ST_FLUSH;
            end else if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_in.destination        = dest_ff;
               rsp_in.out_byte           = need_crlf ? (half_ff ? CH_LF : CH_CR)
                                           : (map_cr ? CH_LF : b);
               rsp_in.interrupt_request  = irq_ff && first_ff;
               rsp_in.last               = step_done && final_slot && !flush_ff;
               first_in                  = 1'b0;
               if (step_done) begin
                  half_in = 1'b0;
                  if (final_slot) begin
                     state_in = flush_ff ? ST_FLUSH : ST_IDLE;
                  end else begin
                     idx_in = idx_ff + 2'd1;
                  end
               end else begin
                  half_in = 1'b1;
               end
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_in.destination       = DST_READER;
               rsp_in.out_byte          = rdata_ff;
               rsp_in.interrupt_request = 1'b0;
               rsp_in.last              = (fidx_ff == fend_ff);
               if (fidx_ff == fend_ff) begin
                  fidx_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  fidx_in = fidx_ff + IDX_W'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         fidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         fidx_ff      <= fidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and sequencing data, no reset needed
   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      half_ff  <= half_in;
      dest_ff  <= dest_in;
      flush_ff <= flush_in;
      irq_ff   <= irq_in;
      first_ff <= first_in;
      fend_ff  <= fend_in;
      rsp_ff   <= rsp_in;
   end

   // line memory: write at the current length, read one entry ahead of the
   // flush position so the data is ready when the output register frees up
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[len_ff[IDX_W-1:0]] <= wr_data;
      end
      rdata_ff <= line_mem[fidx_in];
   end

endmodule

// File: hw/rtl/tld_checker.sv
// ----------------------------------------------------------------------------
// tld_port_checker
// port level checks of the tty line discipline, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tld_port_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input tld_pkg::tld_req_type req_payload,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input tld_pkg::tld_rsp_type rsp_payload
);
   import tld_pkg::*;

   logic req_beat;
   logic rsp_beat;

   assign req_beat = req_valid && req_ready && (req_payload.action == ACT_PROGRAM
                     || req_payload.action == ACT_KEYBOARD);
   assign rsp_beat = rsp_valid && rsp_ready;

   // a stalled result holds
   `TLD_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))

   // no new item while the current one still owes beats
   `TLD_ASSERT(a_busy_mid_item, clock, reset,
      rsp_valid && !rsp_payload.last |-> !req_ready)

   // interrupt only flags display beats
   `TLD_ASSERT(a_irq_display, clock, reset,
      rsp_valid && rsp_payload.interrupt_request |-> rsp_payload.destination == DST_DISPLAY)

   // an accepted item is never followed by an item in the very next cycle
   // unless it produced nothing, so ready drops or stays high with no result
   `TLD_ASSERT(a_accept_then_work, clock, reset,
      req_beat |=> !req_ready || !rsp_valid || $past(rsp_valid))

   // output register is empty after reset
   `TLD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind tty_line_discipline tld_port_checker u_tld_checker (.*);

// File: test/tld_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tld_checker
// watches the req, rsp and csr ports of the tty line discipline, keeps its
// own copy of the registers and the line buffer, predicts every result beat
// and compares the accepted rsp beats field by field in order
// ----------------------------------------------------------------------------
module tld_checker
   import tld_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  tld_req_type       req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  tld_rsp_type       rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output int                fail_count,
   output int                beats_pending,
   output int                beats_checked
);

   localparam int MAX_BEATS = LINE_DEPTH + 2;

   logic [6:0]  mode_flags;
   logic [7:0]  erase_code;
   logic [7:0]  intr_code;
   logic [47:0] ignored_set;

   logic [7:0]  line_mem [LINE_DEPTH];
   int          line_len;

   tld_rsp_type step_beats [MAX_BEATS];
   int          step_count;
   logic        step_irq;

   tld_rsp_type line_beats_q [$];
   int          errors = 0;
   int          checked = 0;

   task automatic add_beat(input logic dest, input logic [7:0] value);
      tld_rsp_type beat;
      beat = '0;
      beat.destination = dest;
      beat.out_byte = value;
      if (step_count < MAX_BEATS) begin
         step_beats[step_count] = beat;
         step_count++;
      end
   endtask

   // display path with output post-processing
   task automatic show(input logic [7:0] value);
      if (mode_flags[M_OPOST] && value == CH_LF && mode_flags[M_ONLCR]) begin
         add_beat(DST_DISPLAY, CH_CR);
         add_beat(DST_DISPLAY, CH_LF);
      end else if (mode_flags[M_OPOST] && value == CH_CR && mode_flags[M_OCRNL]) begin
         add_beat(DST_DISPLAY, CH_LF);
      end else begin
         add_beat(DST_DISPLAY, value);
      end
   endtask

   // caret notation for control bytes
   task automatic echo_char(input logic [7:0] value);
      if (value < CTRL_TOP) begin
         show(CH_CARET);
         show(value + CARET_OFS);
      end else begin
         show(value);
      end
   endtask

   function automatic logic ignored_slot(input logic [7:0] value, input int k);
      return ignored_set[8*k +: 8] == value;
   endfunction

   function automatic logic any_ignored(input logic [7:0] value);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < 6; k++)
         if (ignored_slot(value, k))
            hit = 1'b1;
      return hit;
   endfunction

   task automatic cook_key(input logic [7:0] value);
      logic echo_on;
      echo_on = mode_flags[M_ECHO];
      // eof and eol win over erase and interrupt
      if (ignored_slot(value, 0) || ignored_slot(value, 1)) begin
         if (echo_on)
            echo_char(value);
      end else if (value == erase_code || value == CH_BS) begin
         if (line_len > 0) begin
            line_len--;
            if (mode_flags[M_ECHOE]) begin
               show(CH_BS);
               show(CH_SPACE);
               show(CH_BS);
            end
         end
      end else if (value == intr_code) begin
         step_irq = 1'b1;
         show(CH_CARET);
         show(value + CARET_OFS);
         show(CH_LF);
      end else if (any_ignored(value)) begin
         if (echo_on)
            echo_char(value);
      end else if (value == CH_LF || (value == CH_CR && mode_flags[M_ICRNL])) begin
         line_mem[line_len] = CH_LF;
         line_len++;
         if (echo_on)
            show(CH_LF);
         for (int i = 0; i < line_len; i++)
            add_beat(DST_READER, line_mem[i]);
         line_len = 0;
      end else if (line_len < LINE_DEPTH - 1) begin
         line_mem[line_len] = value;
         line_len++;
         if (echo_on)
            echo_char(value);
      end
   endtask

   task automatic predict_item(input tld_req_type item);
      step_count = 0;
      step_irq = 1'b0;
      if (item.action == ACT_PROGRAM)
         show(item.data_byte);
      else if (!mode_flags[M_CANON])
         add_beat(DST_READER, item.data_byte);
      else
         cook_key(item.data_byte);
      if (step_count > 0) begin
         step_beats[0].interrupt_request = step_irq;
         step_beats[step_count-1].last = 1'b1;
         for (int i = 0; i < step_count; i++)
            line_beats_q.push_back(step_beats[i]);
      end
   endtask

   task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: rsp %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      tld_rsp_type want;
      if (reset) begin
         mode_flags = MODE_RESET;
         erase_code = ERASE_RESET;
         intr_code = INTR_RESET;
         ignored_set = IGNORED_RESET;
         line_len = 0;
         line_beats_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (tld_reg_type'(paddr[CSR_AW-1:3]))
               REG_MODE:    mode_flags = pwdata[6:0];
               REG_ERASE:   erase_code = pwdata[7:0];
               REG_INTR:    intr_code = pwdata[7:0];
               REG_IGNORED: ignored_set = pwdata[47:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_item(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (line_beats_q.size() == 0) begin
               $display("%0t: rsp beat with nothing expected, expected none, actual %h",
                        $time, rsp_payload);
               errors++;
            end else begin
               want = line_beats_q.pop_front();
               check_field("destination", want.destination, rsp_payload.destination);
               check_field("out_byte", want.out_byte, rsp_payload.out_byte);
               check_field("interrupt_request", want.interrupt_request,
                           rsp_payload.interrupt_request);
               check_field("last", want.last, rsp_payload.last);
               checked++;
            end
         end
      end
      // published after the edge so the stimulus side reads settled values
      fail_count <= errors;
      beats_pending <= line_beats_q.size();
      beats_checked <= checked;
   end

endmodule

// File: test/tty_line_discipline_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tty_line_discipline_tb
// drives keyboard and program bytes into the line discipline, changes the
// registers between phases and lets tld_checker predict and compare every
// result beat; three idling patterns on the two channels
// ----------------------------------------------------------------------------
module tty_line_discipline_tb;
   import tld_pkg::*;

   localparam int CLK_HIGH     = 6;
   localparam int CLK_LOW      = 6;
   localparam int RESET_CYCLES = 3;
   localparam int RANDOM_ITEMS = 300;
   localparam int NUM_SETTINGS = 7;
   // a full line flush is 32 beats, so this covers an item still in flight
   localparam int QUIET_CYCLES = 48;
   // cycles with no beat on any port before the run is called hung
   localparam int STALL_LIMIT  = 4000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   tld_req_type       req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   tld_rsp_type       rsp_payload;

   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   int fail_count;
   int beats_pending;
   int beats_checked;

   // idling, in percent of cycles
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   int items_sent = 0;
   int settings_used = 0;
   int idle_cycles = 0;

   // register values as last written, used only to aim the stimulus
   logic [6:0]  cur_mode = MODE_RESET;
   logic [7:0]  cur_erase = ERASE_RESET;
   logic [7:0]  cur_intr = INTR_RESET;
   logic [47:0] cur_ignored = IGNORED_RESET;

   tty_line_discipline u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   tld_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .fail_count    (fail_count),
      .beats_pending (beats_pending),
      .beats_checked (beats_checked)
   );

   // 12 ns clock
   always begin
      #CLK_HIGH clock = 1'b1;
      #CLK_LOW  clock = 1'b0;
   end

   // receiver stalls at random, a fresh decision every cycle
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog: any req, rsp or csr beat restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog, %0d cycles without a beat, %0d beats outstanding",
                  $time, idle_cycles, beats_pending);
         $display("** tty_line_discipline: FAILED **");
         $finish;
      end
   end

   // one req beat; returns at the edge that accepts it with valid still high,
   // so back to back items keep valid up without a glitch
   task automatic send_item(input logic act, input logic [7:0] value);
      tld_req_type beat_in;
      beat_in.action = act;
      beat_in.data_byte = value;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= beat_in;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
   endtask

   // wait until every predicted beat is out, then give a silent item time to finish
   task automatic drain();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (beats_pending != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle and access cycle, then psel dropped again before returning
   task automatic csr_write(input tld_reg_type idx, input logic [CSR_DW-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [6:0] mode, input logic [7:0] erase,
                                input logic [7:0] intr, input logic [47:0] ignored);
      drain();
      csr_write(REG_MODE, CSR_DW'(mode));
      csr_write(REG_ERASE, CSR_DW'(erase));
      csr_write(REG_INTR, CSR_DW'(intr));
      csr_write(REG_IGNORED, CSR_DW'(ignored));
      cur_mode = mode;
      cur_erase = erase;
      cur_intr = intr;
      cur_ignored = ignored;
      settings_used++;
   endtask

   // keyboard byte, biased toward the characters the current setting treats specially
   function automatic logic [7:0] pick_key_byte();
      int roll;
      int slot;
      roll = $urandom_range(99);
      slot = $urandom_range(5);
      if (roll < 50)
         return 8'($urandom_range(8'h7E, 8'h20));
      else if (roll < 62)
         return 8'($urandom_range(255));
      else if (roll < 72)
         return $urandom_range(1) ? cur_erase : CH_BS;
      else if (roll < 76)
         return cur_intr;
      else if (roll < 86)
         return cur_ignored[8*slot +: 8];
      else
         return 8'($urandom_range(8'h1F));
   endfunction

   // one typed line ending in LF or CR; some lines are plain text from just short
   // of a full buffer to past it, others a short mix with program output interleaved
   task automatic send_line();
      int len;
      logic fill;
      fill = ($urandom_range(7) == 0);
      len = fill ? $urandom_range(LINE_DEPTH + 6, LINE_DEPTH - 2) : $urandom_range(8);
      repeat (len) begin
         if (fill)
            send_item(ACT_KEYBOARD, 8'($urandom_range(8'h7E, 8'h20)));
         else if ($urandom_range(9) == 0)
            send_item(ACT_PROGRAM, 8'($urandom_range(255)));
         else
            send_item(ACT_KEYBOARD, pick_key_byte());
      end
      send_item(ACT_KEYBOARD, $urandom_range(1) ? CH_LF : CH_CR);
   endtask

   task automatic run_random(input int count);
      int stop_at;
      int roll;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 75) begin
            send_line();
         end else if (roll < 90) begin
            // noise: any source, any byte
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
         end else begin
            // program output burst, newlines and returns included
            repeat ($urandom_range(6, 1))
               send_item(ACT_PROGRAM, $urandom_range(1) ? 8'($urandom_range(255))
                                                        : ($urandom_range(1) ? CH_LF : CH_CR));
         end
      end
   endtask

   initial begin
      send_idle_pct = 33;
      recv_idle_pct = 66;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset settings
      // program output: plain, newline to cr lf, cr left alone, top and bottom bytes
      send_item(ACT_PROGRAM, 8'h41);
      send_item(ACT_PROGRAM, CH_LF);
      send_item(ACT_PROGRAM, CH_CR);
      send_item(ACT_PROGRAM, 8'hFF);
      send_item(ACT_PROGRAM, 8'h00);
      // erase on an empty line gives no beat
      send_item(ACT_KEYBOARD, CH_BS);
      // zero is eof here, so it is echoed as ^@ and not taken as erase
      send_item(ACT_KEYBOARD, 8'h00);
      send_item(ACT_KEYBOARD, 8'h68);
      send_item(ACT_KEYBOARD, 8'h01);
      send_item(ACT_KEYBOARD, 8'h80);
      send_item(ACT_KEYBOARD, 8'hFF);
      // erase with bs space bs echo
      send_item(ACT_KEYBOARD, CH_BS);
      // interrupt: ^C and newline, request flag on the first beat
      send_item(ACT_KEYBOARD, INTR_RESET);
      // kill, quit, start, susp: echoed, not stored
      send_item(ACT_KEYBOARD, 8'h15);
      send_item(ACT_KEYBOARD, 8'h1C);
      send_item(ACT_KEYBOARD, 8'h11);
      send_item(ACT_KEYBOARD, 8'h1A);
      // cr mapped to newline flushes the line, then an empty line
      send_item(ACT_KEYBOARD, CH_CR);
      send_item(ACT_KEYBOARD, CH_LF);

      // random part, one register setting per block
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         // idling pattern: sender light / receiver heavy, then swapped, then none
         case (s * 3 / NUM_SETTINGS)
            0: begin
               send_idle_pct = 33;
               recv_idle_pct = 66;
            end
            1: begin
               send_idle_pct = 66;
               recv_idle_pct = 33;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (s)
            0: apply_setting(MODE_RESET, 8'h7F, INTR_RESET, IGNORED_RESET);
            // every flag on; interrupt echo turns into a newline, ignored set all zero
            1: apply_setting(7'h7F, 8'h00, 8'hCA, 48'h0);
            // raw, no post-processing, every other register at its top
            2: apply_setting(7'h00, 8'hFF, 8'hFF, 48'hFFFF_FFFF_FFFF);
            // canonical with echo off
            3: apply_setting(7'h01, CH_BS, 8'hCD, 48'({$urandom, $urandom}));
            // echo with cr to nl on output, cr not a line end on input
            4: apply_setting(7'h53, 8'($urandom_range(255)), 8'hCD, 48'({$urandom, $urandom}));
            5: apply_setting(7'($urandom_range(127)), 8'($urandom_range(255)),
                             8'($urandom_range(255)), 48'({$urandom, $urandom}));
            // raw keyboard with both output maps on
            default: apply_setting(7'h72, 8'($urandom_range(255)), 8'($urandom_range(255)),
                                   48'({$urandom, $urandom}));
         endcase
         run_random(RANDOM_ITEMS / NUM_SETTINGS);
      end

      drain();
      $display("ran %0d items through %0d register settings under three idling patterns",
               items_sent, settings_used);
      $display("%0d result beats compared, %0d never arrived", beats_checked, beats_pending);
      if (fail_count == 0 && beats_pending == 0)
         $display("** tty_line_discipline: PASSED **");
      else
         $display("** tty_line_discipline: FAILED **");
      $finish;
   end

endmodule
